[rtl/best_fit_heap_allocator_unit_macros.svh]
// ----------------------------------------------------------------------------
// best-fit heap allocator assertion macros
// shared concurrent assertion forms used at the top level
// ----------------------------------------------------------------------------
`ifndef BEST_FIT_HEAP_ALLOCATOR_UNIT_MACROS_SVH
`define BEST_FIT_HEAP_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication
`define BFHA_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BFHA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/bfha_pkg.sv]
// ----------------------------------------------------------------------------
// bfha_pkg
// constants, types and command codes of the best-fit heap allocator
// ----------------------------------------------------------------------------
`default_nettype none

package bfha_pkg;

    localparam int HEAP_WORDS   = 2048;
    localparam int WORD_BYTES   = 4;
    localparam int HEAP_BYTES   = HEAP_WORDS * WORD_BYTES;
    localparam int ALIGN_BYTES  = 4;
    localparam int HEADER_WORDS = 3;
    localparam int HDR_BYTES    = HEADER_WORDS * WORD_BYTES;
    localparam int MAX_BLOCKS   = HEAP_BYTES / HDR_BYTES + 1;
    localparam int IDX_W        = $clog2(MAX_BLOCKS + 1);

    localparam int SIZE_W = 14;
    localparam int REQ_W  = 15;
    localparam int ADDR_W = 13;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_BAD_FREE = 2'd2
    } status_t;

    typedef struct packed {
        logic              used;
        logic [SIZE_W-1:0] size;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_INIT,
        CMD_LOAD,
        CMD_READ,
        CMD_AL_EVAL,
        CMD_FR_EVAL,
        CMD_J_TAIL,
        CMD_UP_RD,
        CMD_UP_WR,
        CMD_SPLIT_NEW,
        CMD_SPLIT_USE,
        CMD_NOSPLIT,
        CMD_NOFIT,
        CMD_BAD,
        CMD_FR_NEXT,
        CMD_MERGE,
        CMD_DN_RD,
        CMD_DN_WR,
        CMD_FR_DONE,
        CMD_EMIT
    } cmd_t;

    typedef struct packed {
        logic op_free;
        logic at_end;
        logic match;
        logic hit_used;
        logic has_next;
        logic found;
        logic can_split;
        logic up_done;
        logic dn_done;
        logic out_stall;
    } dp_stat_t;

endpackage

`default_nettype wire

[rtl/bfha_ram.sv]
// ----------------------------------------------------------------------------
// bfha_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module bfha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/bfha_ctrl.sv]
// ----------------------------------------------------------------------------
// bfha_ctrl
// sequencer for allocate and free: scans, shifts and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module bfha_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire bfha_pkg::dp_stat_t stat,
    output bfha_pkg::cmd_t         cmd
);

    import bfha_pkg::*;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_RD, S_AEVAL, S_FEVAL, S_ADEC,
        S_UP_CHK, S_UP_RD, S_UP_WR, S_SPL1, S_SPL2, S_NOSPL,
        S_NOFIT, S_BAD, S_FNEXT, S_MERGE, S_DN_CHK, S_DN_RD,
        S_DN_WR, S_FDONE, S_EMIT
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        unique case (state_reg)
            S_INIT: begin
                cmd        = CMD_INIT;
                state_next = S_IDLE;
            end
            S_IDLE: begin
                if (in_valid) begin
                    cmd        = CMD_LOAD;
                    state_next = S_RD;
                end
            end
            S_RD: begin
                cmd        = CMD_READ;
                state_next = stat.op_free ? S_FEVAL : S_AEVAL;
            end
            S_AEVAL: begin
                cmd        = CMD_AL_EVAL;
                state_next = stat.at_end ? S_ADEC : S_RD;
            end
            S_ADEC: begin
                cmd = CMD_J_TAIL;
                if (!stat.found) state_next = S_NOFIT;
                else if (stat.can_split) state_next = S_UP_CHK;
                else state_next = S_NOSPL;
            end
            S_UP_CHK: state_next = stat.up_done ? S_SPL1 : S_UP_RD;
            S_UP_RD: begin
                cmd        = CMD_UP_RD;
                state_next = S_UP_WR;
            end
            S_UP_WR: begin
                cmd        = CMD_UP_WR;
                state_next = S_UP_CHK;
            end
            S_SPL1: begin
                cmd        = CMD_SPLIT_NEW;
                state_next = S_SPL2;
            end
            S_SPL2: begin
                cmd        = CMD_SPLIT_USE;
                state_next = S_EMIT;
            end
            S_NOSPL: begin
                cmd        = CMD_NOSPLIT;
                state_next = S_EMIT;
            end
            S_NOFIT: begin
                cmd        = CMD_NOFIT;
                state_next = S_EMIT;
            end
            S_BAD: begin
                cmd        = CMD_BAD;
                state_next = S_EMIT;
            end
            S_FEVAL: begin
                cmd = CMD_FR_EVAL;
                if (stat.match) begin
                    if (!stat.hit_used) state_next = S_BAD;
                    else if (stat.has_next) state_next = S_FNEXT;
                    else state_next = S_MERGE;
                end else if (stat.at_end) begin
                    state_next = S_BAD;
                end else begin
                    state_next = S_RD;
                end
            end
            S_FNEXT: begin
                cmd        = CMD_FR_NEXT;
                state_next = S_MERGE;
            end
            S_MERGE: begin
                cmd        = CMD_MERGE;
                state_next = S_DN_CHK;
            end
            S_DN_CHK: state_next = stat.dn_done ? S_FDONE : S_DN_RD;
            S_DN_RD: begin
                cmd        = CMD_DN_RD;
                state_next = S_DN_WR;
            end
            S_DN_WR: begin
                cmd        = CMD_DN_WR;
                state_next = S_DN_CHK;
            end
            S_FDONE: begin
                cmd        = CMD_FR_DONE;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (!stat.out_stall) begin
                    cmd        = CMD_EMIT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_INIT;
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[rtl/bfha_datapath.sv]
// ----------------------------------------------------------------------------
// bfha_datapath
// block table memory, scan registers, merge and split arithmetic, result register
// ----------------------------------------------------------------------------
`default_nettype none

module bfha_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire bfha_pkg::cmd_t                cmd,
    output bfha_pkg::dp_stat_t                 stat,
    input  wire logic                          in_free,
    input  wire logic [bfha_pkg::SIZE_W-1:0]   in_size,
    input  wire logic [bfha_pkg::ADDR_W-1:0]   in_addr,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [1:0]                         out_status,
    output logic [bfha_pkg::ADDR_W-1:0]        out_addr,
    output logic [bfha_pkg::SIZE_W-1:0]        out_free
);

    import bfha_pkg::*;

    localparam logic [SIZE_W-1:0] HDR_S  = SIZE_W'(HDR_BYTES);
    localparam logic [REQ_W-1:0]  HDR_R  = REQ_W'(HDR_BYTES);
    localparam logic [SIZE_W-1:0] HEAP_S = SIZE_W'(HEAP_BYTES);
    localparam logic [SIZE_W-1:0] INIT_FREE = SIZE_W'(HEAP_BYTES - HDR_BYTES);
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(MAX_BLOCKS - 1);

    logic [IDX_W-1:0]  tail_reg, idx_reg, best_reg, j_reg;
    logic [1:0]        removed_reg;
    logic [SIZE_W-1:0] free_total_reg, pos_reg, best_size_reg, best_start_reg;
    logic [SIZE_W-1:0] prev_size_reg, hit_size_reg;
    logic [REQ_W-1:0]  req_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic              op_free_reg, found_reg, prev_used_reg;
    status_t           res_status_reg;
    logic [ADDR_W-1:0] res_addr_reg;
    logic              out_valid_reg;
    logic [1:0]        out_status_reg;
    logic [ADDR_W-1:0] out_addr_reg;
    logic [SIZE_W-1:0] out_free_reg;

    logic              we, re;
    logic [IDX_W-1:0]  waddr, raddr;
    entry_t            wdata, rd;

    logic              fit, prev_free, next_free;
    logic [SIZE_W-1:0] blk_start, merged;
    logic [REQ_W-1:0]  rem;
    logic [IDX_W-1:0]  j_src;

    bfha_ram #(.WIDTH(ENTRY_W), .DEPTH(1 << IDX_W)) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rd)
    );

    assign fit = !rd.used && ({1'b0, rd.size} >= req_reg)
                 && (!found_reg || (best_size_reg > rd.size));
    assign blk_start = pos_reg - HDR_S - rd.size;
    assign rem       = {1'b0, best_size_reg} - req_reg;
    assign prev_free = (idx_reg != '0) && !prev_used_reg;
    assign next_free = stat.has_next && !rd.used;
    assign merged    = hit_size_reg + (prev_free ? HDR_S + prev_size_reg : '0)
                       + (next_free ? HDR_S + rd.size : '0);
    assign j_src     = j_reg + IDX_W'(removed_reg);

    always_comb begin
        stat.op_free   = op_free_reg;
        stat.at_end    = op_free_reg ? (idx_reg == tail_reg) : (idx_reg == '0);
        stat.match     = (pos_reg + HDR_S) == {1'b0, addr_reg};
        stat.hit_used  = rd.used;
        stat.has_next  = idx_reg < tail_reg;
        stat.found     = found_reg;
        stat.can_split = (rem > HDR_R) && (tail_reg < LAST_IDX);
        stat.up_done   = (j_reg == best_reg);
        stat.dn_done   = j_src > tail_reg;
        stat.out_stall = out_valid_reg && !out_ready;
    end

    always_comb begin
        we    = 1'b0;
        waddr = '0;
        wdata = rd;
        re    = 1'b0;
        raddr = idx_reg;
        case (cmd)
            CMD_INIT: begin
                we    = 1'b1;
                wdata = '{used: 1'b0, size: INIT_FREE};
            end
            CMD_READ:    re = 1'b1;
            CMD_UP_RD: begin
                re    = 1'b1;
                raddr = j_reg;
            end
            CMD_UP_WR: begin
                we    = 1'b1;
                waddr = j_reg + 1'b1;
            end
            CMD_SPLIT_NEW: begin
                we    = 1'b1;
                waddr = best_reg + 1'b1;
                wdata = '{used: 1'b0, size: SIZE_W'(rem - HDR_R)};
            end
            CMD_SPLIT_USE: begin
                we    = 1'b1;
                waddr = best_reg;
                wdata = '{used: 1'b1, size: req_reg[SIZE_W-1:0]};
            end
            CMD_NOSPLIT: begin
                we    = 1'b1;
                waddr = best_reg;
                wdata = '{used: 1'b1, size: best_size_reg};
            end
            CMD_FR_NEXT: begin
                re    = 1'b1;
                raddr = idx_reg + 1'b1;
            end
            CMD_MERGE: begin
                we    = 1'b1;
                waddr = prev_free ? idx_reg - 1'b1 : idx_reg;
                wdata = '{used: 1'b0, size: merged};
            end
            CMD_DN_RD: begin
                re    = 1'b1;
                raddr = j_src;
            end
            CMD_DN_WR: begin
                we    = 1'b1;
                waddr = j_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tail_reg       <= '0;
            free_total_reg <= INIT_FREE;
            out_valid_reg  <= 1'b0;
        end else begin
            if (out_valid_reg && out_ready && (cmd != CMD_EMIT)) begin
                out_valid_reg <= 1'b0;
            end
            case (cmd)
                CMD_LOAD: begin
                    op_free_reg   <= in_free;
                    req_reg       <= REQ_W'((({1'b0, in_size} + REQ_W'(ALIGN_BYTES - 1))
                                     / ALIGN_BYTES) * ALIGN_BYTES);
                    addr_reg      <= in_addr;
                    found_reg     <= 1'b0;
                    prev_used_reg <= 1'b1;
                    idx_reg       <= in_free ? '0 : tail_reg;
                    pos_reg       <= in_free ? '0 : HEAP_S;
                end
                CMD_AL_EVAL: begin
                    if (fit) begin
                        found_reg      <= 1'b1;
                        best_reg       <= idx_reg;
                        best_size_reg  <= rd.size;
                        best_start_reg <= blk_start;
                    end
                    pos_reg <= blk_start;
                    idx_reg <= idx_reg - 1'b1;
                end
                CMD_FR_EVAL: begin
                    if (stat.match) begin
                        hit_size_reg <= rd.size;
                    end else begin
                        prev_used_reg <= rd.used;
                        prev_size_reg <= rd.size;
                        pos_reg       <= pos_reg + HDR_S + rd.size;
                        idx_reg       <= idx_reg + 1'b1;
                    end
                end
                CMD_J_TAIL: j_reg <= tail_reg;
                CMD_UP_WR:  j_reg <= j_reg - 1'b1;
                CMD_SPLIT_USE: begin
                    tail_reg       <= tail_reg + 1'b1;
                    free_total_reg <= free_total_reg - req_reg[SIZE_W-1:0];
                    res_status_reg <= ST_OK;
                    res_addr_reg   <= ADDR_W'(best_start_reg + HDR_S);
                end
                CMD_NOSPLIT: begin
                    free_total_reg <= free_total_reg - best_size_reg;
                    res_status_reg <= ST_OK;
                    res_addr_reg   <= ADDR_W'(best_start_reg + HDR_S);
                end
                CMD_NOFIT: begin
                    res_status_reg <= ST_NO_SPACE;
                    res_addr_reg   <= '0;
                end
                CMD_BAD: begin
                    res_status_reg <= ST_BAD_FREE;
                    res_addr_reg   <= '0;
                end
                CMD_MERGE: begin
                    j_reg          <= (prev_free ? idx_reg - 1'b1 : idx_reg) + 1'b1;
                    removed_reg    <= {1'b0, prev_free} + {1'b0, next_free};
                    free_total_reg <= free_total_reg + hit_size_reg;
                end
                CMD_DN_WR: j_reg <= j_reg + 1'b1;
                CMD_FR_DONE: begin
                    tail_reg       <= tail_reg - IDX_W'(removed_reg);
                    res_status_reg <= ST_OK;
                    res_addr_reg   <= '0;
                end
                CMD_EMIT: begin
                    out_valid_reg  <= 1'b1;
                    out_status_reg <= res_status_reg;
                    out_addr_reg   <= res_addr_reg;
                    out_free_reg   <= free_total_reg;
                end
                default: ;
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_addr   = out_addr_reg;
    assign out_free   = out_free_reg;

endmodule

`default_nettype wire

[rtl/best_fit_heap_allocator_unit.sv]
// ----------------------------------------------------------------------------
// best_fit_heap_allocator_unit
// best-fit heap allocator with split on allocate and coalescing on free
// ----------------------------------------------------------------------------
// The heap is kept as an address-ordered table of block entries (used mark and
// payload size) in one block ram with a registered read, one entry per cycle
// on each port. After reset the S_INIT state writes the initial free block
// before the first transaction is taken. An allocate reads every block from
// the tail through the S_RD and S_AEVAL states, and a split then moves every
// entry above the chosen block up by one through S_UP_CHK, S_UP_RD and
// S_UP_WR. A free scans from the head to the addressed block through S_RD and
// S_FEVAL, then moves the entries above a merge down through S_DN_CHK, S_DN_RD
// and S_DN_WR. One transaction is in flight at a time; a finished result sits
// in the output register while the next request is taken.
`default_nettype none
`include "best_fit_heap_allocator_unit_macros.svh"

module best_fit_heap_allocator_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,  // size_bytes[13:0], block_address[26:14]
    input  wire logic [0:0]  s_tuser,  // operation[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata   // status[1:0], granted_address[14:2], free_bytes[28:15]
);

    import bfha_pkg::*;

    cmd_t              cmd;
    dp_stat_t          stat;
    logic [1:0]        out_status;
    logic [ADDR_W-1:0] out_addr;
    logic [SIZE_W-1:0] out_free;

    bfha_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bfha_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_free    (s_tuser[0]),
        .in_size    (s_tdata[13:0]),
        .in_addr    (s_tdata[26:14]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (out_status),
        .out_addr   (out_addr),
        .out_free   (out_free)
    );

    assign m_tdata = {3'b000, out_free, out_addr, out_status};

    `BFHA_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "ready held after accept")
    `BFHA_ASSERT_NOW(a_addr_zero_on_error, aclk, aresetn, m_tvalid && (out_status != ST_OK), out_addr == '0, "granted address set on error")
    `BFHA_ASSERT_NOW(a_free_bound, aclk, aresetn, m_tvalid, out_free <= SIZE_W'(HEAP_BYTES - HDR_BYTES), "free bytes beyond heap")

endmodule

`default_nettype wire

[dv/best_fit_heap_allocator_unit_tb.sv]
// ----------------------------------------------------------------------------
// best_fit_heap_allocator_unit_tb
// drives allocate and free transactions into the heap allocator, keeps its
// own block table to predict every status, granted offset and free count,
// and compares each result against the oldest outstanding prediction
// ----------------------------------------------------------------------------
`default_nettype none

module best_fit_heap_allocator_unit_tb;
    import bfha_pkg::*;

    typedef struct {
        int unsigned start;
        int unsigned size;
        bit          used;
    } heap_blk_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] free_b;
    } alloc_rsp_t;

    localparam int CYCLE_LIMIT = 4000000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;

    heap_blk_t    heap_tbl[$];
    int unsigned  heap_free;
    alloc_rsp_t   rsp_pending[$];
    int unsigned  live_addrs[$];
    int           mismatch_cnt;
    int           rsp_cnt;
    int           alloc_cnt;
    int           free_cnt;
    int           err_cnt;
    longint       cycle_cnt;
    bit           src_idle_en;
    bit           snk_idle_en;
    int           snk_hold;

    best_fit_heap_allocator_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic void heap_reset();
        heap_blk_t b;
        heap_tbl.delete();
        b.start = 0;
        b.size  = HEAP_BYTES - HDR_BYTES;
        b.used  = 1'b0;
        heap_tbl.push_back(b);
        heap_free = HEAP_BYTES - HDR_BYTES;
    endfunction

    function automatic alloc_rsp_t heap_alloc(int unsigned sz);
        alloc_rsp_t r;
        int unsigned req;
        int best;
        heap_blk_t nb;
        req  = ((sz + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
        best = -1;
        for (int i = heap_tbl.size() - 1; i >= 0; i--) begin
            if (!heap_tbl[i].used && heap_tbl[i].size >= req &&
                (best < 0 || heap_tbl[best].size > heap_tbl[i].size))
                best = i;
        end
        r.addr = '0;
        if (best < 0) begin
            r.status = ST_NO_SPACE;
        end else begin
            if (heap_tbl[best].size - req > HDR_BYTES && heap_tbl.size() < MAX_BLOCKS) begin
                nb.start = heap_tbl[best].start + HDR_BYTES + req;
                nb.size  = heap_tbl[best].size - req - HDR_BYTES;
                nb.used  = 1'b0;
                heap_tbl.insert(best + 1, nb);
                heap_tbl[best].size = req;
            end
            heap_tbl[best].used = 1'b1;
            heap_free -= heap_tbl[best].size;
            r.status = ST_OK;
            r.addr   = ADDR_W'(heap_tbl[best].start + HDR_BYTES);
        end
        r.free_b = SIZE_W'(heap_free);
        return r;
    endfunction

    function automatic alloc_rsp_t heap_release(int unsigned ad);
        alloc_rsp_t r;
        int idx;
        idx = -1;
        for (int i = 0; i < heap_tbl.size(); i++) begin
            if (heap_tbl[i].start + HDR_BYTES == ad) begin
                idx = i;
                break;
            end
        end
        r.addr = '0;
        if (idx < 0 || !heap_tbl[idx].used) begin
            r.status = ST_BAD_FREE;
        end else begin
            heap_tbl[idx].used = 1'b0;
            heap_free += heap_tbl[idx].size;
            while (idx > 0 && !heap_tbl[idx-1].used)
                idx--;
            while (idx < heap_tbl.size() - 1 && !heap_tbl[idx+1].used) begin
                heap_tbl[idx].size += HDR_BYTES + heap_tbl[idx+1].size;
                heap_tbl.delete(idx + 1);
            end
            r.status = ST_OK;
        end
        r.free_b = SIZE_W'(heap_free);
        return r;
    endfunction

    // one transaction into the block, prediction made when accepted
    task automatic send_op(bit is_free, int unsigned sz, int unsigned ad);
        alloc_rsp_t r;
        @(negedge aclk);
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= is_free;
        s_tdata  <= {5'd0, ad[12:0], sz[13:0]};
        do @(posedge aclk); while (!s_tready);
        if (is_free) begin
            r = heap_release(ad);
            free_cnt++;
            if (r.status == ST_OK) begin
                foreach (live_addrs[i])
                    if (live_addrs[i] == ad) begin
                        live_addrs.delete(i);
                        break;
                    end
            end else begin
                err_cnt++;
            end
        end else begin
            r = heap_alloc(sz);
            alloc_cnt++;
            if (r.status == ST_OK)
                live_addrs.push_back(r.addr);
        end
        rsp_pending.push_back(r);
    endtask

    always @(posedge aclk) begin
        alloc_rsp_t got;
        alloc_rsp_t exp;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = m_tdata[1:0];
            got.addr   = m_tdata[14:2];
            got.free_b = m_tdata[28:15];
            rsp_cnt++;
            if (rsp_pending.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result %h", m_tdata);
            end else begin
                exp = rsp_pending.pop_front();
                if (got !== exp) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: exp st=%0d ad=%0d fb=%0d got st=%0d ad=%0d fb=%0d",
                                 exp.status, exp.addr, exp.free_b,
                                 got.status, got.addr, got.free_b);
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (snk_hold > 0) begin
            snk_hold <= snk_hold - 1;
            m_tready <= 1'b0;
        end else if (snk_idle_en && $urandom_range(0, 5) == 0) begin
            snk_hold <= $urandom_range(0, 9);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (rsp_pending.size() != 0)
            @(posedge aclk);
        repeat (3000) @(posedge aclk);
    endtask

    task automatic test_directed();
        send_op(1'b0, 0, 0);
        send_op(1'b0, 1, 0);
        send_op(1'b0, 8192, 0);
        send_op(1'b0, 16383, 0);
        send_op(1'b0, 100, 0);
        send_op(1'b0, 100, 0);
        send_op(1'b0, 40, 0);
        send_op(1'b1, 0, HDR_BYTES);
        send_op(1'b1, 0, HDR_BYTES);
        send_op(1'b1, 0, 8191);
        send_op(1'b1, 0, 5);
        send_op(1'b0, 0, 0);
        // the frees leave one 100-byte hole that the 97-byte request, rounded up, fits exactly
        send_op(1'b1, 16383, live_addrs[1]);
        send_op(1'b1, 0, live_addrs[2]);
        send_op(1'b0, 97, 0);
        while (live_addrs.size() != 0)
            send_op(1'b1, 0, live_addrs[0]);
        send_op(1'b0, HEAP_BYTES - HDR_BYTES, 0);
        send_op(1'b0, 0, 0);
        send_op(1'b1, 0, HDR_BYTES);
        send_op(1'b0, HEAP_BYTES - 2 * HDR_BYTES - 4, 0);
        send_op(1'b1, 0, HDR_BYTES);
    endtask

    task automatic test_random(int n);
        int unsigned sz;
        int unsigned ad;
        for (int k = 0; k < n; k++) begin
            if (live_addrs.size() == 0 || $urandom_range(0, 9) < 5) begin
                case ($urandom_range(0, 9))
                    0:       sz = $urandom_range(0, 16383);
                    1:       sz = $urandom_range(1000, 8192);
                    default: sz = $urandom_range(0, 300);
                endcase
                send_op(1'b0, sz, $urandom_range(0, 8191));
            end else if ($urandom_range(0, 9) == 0) begin
                ad = $urandom_range(0, 8191);
                send_op(1'b1, $urandom_range(0, 16383), ad);
            end else begin
                ad = live_addrs[$urandom_range(0, live_addrs.size() - 1)];
                send_op(1'b1, $urandom_range(0, 16383), ad);
            end
        end
    endtask

    // sink stalls long enough for the output register to back up
    task automatic test_backpressure();
        snk_hold = 400;
        for (int k = 0; k < 6; k++)
            send_op(1'b0, $urandom_range(0, 64), 0);
    endtask

    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        m_tready     = 1'b0;
        mismatch_cnt = 0;
        rsp_cnt      = 0;
        alloc_cnt    = 0;
        free_cnt     = 0;
        err_cnt      = 0;
        cycle_cnt    = 0;
        snk_hold     = 0;
        src_idle_en  = 1'b1;
        snk_idle_en  = 1'b1;
        heap_reset();
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        test_directed();
        test_backpressure();
        test_random(200);
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        test_random(60);
        wait_drained();
        $display("covered %0d allocates and %0d frees (%0d rejected), %0d results checked",
                 alloc_cnt, free_cnt, err_cnt, rsp_cnt);
        if (mismatch_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches", mismatch_cnt);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
+incdir+rtl
rtl/bfha_pkg.sv
rtl/bfha_ram.sv
rtl/bfha_ctrl.sv
rtl/bfha_datapath.sv
rtl/best_fit_heap_allocator_unit.sv
dv/best_fit_heap_allocator_unit_tb.sv
